// ===== hdl/ucrf_pkg.sv =====
// ----------------------------------------------------------------------------
// ucrf_pkg: shared types and constants for the UART channel register block
// Beat payloads, FIFO sizing and the operation codes of an input beat.
// ----------------------------------------------------------------------------
package ucrf_pkg;

  // Receive FIFO sizing; holds at most FIFO_DEPTH - 1 bytes
  localparam int unsigned FIFO_DEPTH = 256;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

  typedef logic [FIFO_PTR_W-1:0] ucrf_ptr_t;

  // Operation codes of an input beat (code 3 does nothing)
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_RX    = 2'd2;

  typedef struct packed {
    logic [1:0] operation;
    logic [3:0] address;
    logic [7:0] data;
  } ucrf_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_data;
    logic       irq_tx_ready;
    logic       irq_rx_ready;
  } ucrf_out_t;

  // Register file to FIFO requests, at most one per beat
  typedef struct packed {
    logic       push;
    logic       pop;
    logic       clear;
    logic [7:0] wdata;
  } ucrf_fifo_ctl_t;

  // FIFO state seen by the register file
  typedef struct packed {
    ucrf_ptr_t  count;
    logic [7:0] head_data;
  } ucrf_fifo_sts_t;

endpackage

// ===== hdl/uart_channel_regs_rx_fifo.sv =====
// ----------------------------------------------------------------------------
// uart_channel_regs_rx_fifo: one UART channel behind bus registers
// Bus reads, bus writes and line bytes pass through an input register, one
// decode step against the register file and receive FIFO, and a result
// register.
//
//   channel  handshake               payload
//   in       in_valid_i/in_stall_o   in_data_i   (ucrf_in_t)
//   out      out_valid_o/out_stall_i out_data_o  (ucrf_out_t)
//   cfg      cfg_we_i                cfg_wdata_i (port select)
//
// One beat per cycle sustained while the output is not stalled; a result is
// registered in the result register once its beat leaves the input register.
// The combinational decode between input and result register sets that rate.
// Reset clears the register file, FIFO pointers and both valid flags; the
// FIFO store itself is not cleared and needs no sweep.
// A stalled result holds in the output register; the input register can still
// take a beat until it too is full.
// ----------------------------------------------------------------------------
module uart_channel_regs_rx_fifo
  import ucrf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ucrf_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ucrf_out_t out_data_o,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i
);

  logic           item_valid_q;
  ucrf_in_t       item_q;
  logic           out_valid_q;
  ucrf_out_t      out_q;
  logic           port_sel_q;
  logic           out_free;
  logic           fire;
  logic           in_take;
  ucrf_fifo_ctl_t fifo_ctl;
  ucrf_fifo_sts_t fifo_sts;
  ucrf_out_t      result;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = item_valid_q && out_free;
  assign in_stall_o = item_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      port_sel_q   <= 1'b0;
    end else begin
      if (in_take) begin
        item_valid_q <= 1'b1;
      end else if (fire) begin
        item_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        port_sel_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= in_data_i;
    end
    if (fire) begin
      out_q <= result;
    end
  end

  ucrf_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .item_i     (item_q),
    .port_sel_i (port_sel_q),
    .fifo_sts_i (fifo_sts),
    .fifo_ctl_o (fifo_ctl),
    .result_o   (result)
  );

  ucrf_rx_fifo u_rx_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (fifo_ctl),
    .sts_o  (fifo_sts)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/ucrf_rx_fifo.sv =====
// ----------------------------------------------------------------------------
// ucrf_rx_fifo: receive byte FIFO
// Circular store with head pointer and fill count. The head entry is read
// every cycle into a register, with bypass of a write to the same slot, so the
// byte at the head is ready for a holding register read in any cycle.
// ----------------------------------------------------------------------------
module ucrf_rx_fifo
  import ucrf_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ucrf_fifo_ctl_t ctl_i,
  output ucrf_fifo_sts_t sts_o
);

  localparam int unsigned SUM_W    = FIFO_PTR_W + 1;
  localparam ucrf_ptr_t   CNT_MAX  = FIFO_PTR_W'(FIFO_DEPTH - 1);
  localparam logic [SUM_W-1:0] DEPTH_W = SUM_W'(FIFO_DEPTH);

  logic [7:0] mem_q [FIFO_DEPTH];
  logic [7:0] rd_q;
  ucrf_ptr_t  head_q, head_d;
  ucrf_ptr_t  count_q, count_d;
  logic [SUM_W-1:0] slot_sum;
  ucrf_ptr_t  wr_slot;

  // Tail slot: head + count, wrapped once
  always_comb begin
    slot_sum = {1'b0, head_q} + {1'b0, count_q};
    if (slot_sum >= DEPTH_W) begin
      slot_sum = slot_sum - DEPTH_W;
    end
    wr_slot = slot_sum[FIFO_PTR_W-1:0];
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (ctl_i.clear) begin
      head_d  = '0;
      count_d = '0;
    end else if (ctl_i.pop) begin
      head_d  = (head_q == CNT_MAX) ? '0 : head_q + 1'b1;
      count_d = count_q - 1'b1;
    end else if (ctl_i.push) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem_q[wr_slot] <= ctl_i.wdata;
    end
    if (ctl_i.push && (wr_slot == head_d)) begin
      rd_q <= ctl_i.wdata;
    end else begin
      rd_q <= mem_q[head_d];
    end
  end

  assign sts_o.count     = count_q;
  assign sts_o.head_data = rd_q;

  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.push |-> (count_q < CNT_MAX))
    else $error("push into a full receive FIFO");

  a_no_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.pop |-> (count_q != '0))
    else $error("pop from an empty receive FIFO");

  a_one_request : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl_i.push, ctl_i.pop, ctl_i.clear}))
    else $error("more than one FIFO request in a beat");

endmodule

// ===== hdl/ucrf_regs.sv =====
// ----------------------------------------------------------------------------
// ucrf_regs: channel register file and beat decode
// Decodes one beat against the mode, status, command and holding registers,
// raises FIFO requests and builds the result. State moves only on fire_i.
// ----------------------------------------------------------------------------
module ucrf_regs
  import ucrf_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  ucrf_in_t       item_i,
  input  logic           port_sel_i,
  input  ucrf_fifo_sts_t fifo_sts_i,
  output ucrf_fifo_ctl_t fifo_ctl_o,
  output ucrf_out_t      result_o
);

  localparam ucrf_ptr_t CNT_MAX = FIFO_PTR_W'(FIFO_DEPTH - 1);
  localparam ucrf_ptr_t CNT_TWO = FIFO_PTR_W'(2);
  localparam ucrf_ptr_t CNT_ONE = FIFO_PTR_W'(1);

  // Address bank for each port: A at 0..3, B at 8..11
  localparam logic [1:0] BANK_A = 2'b00;
  localparam logic [1:0] BANK_B = 2'b10;

  localparam logic [1:0] REG_MODE    = 2'd0;
  localparam logic [1:0] REG_STATUS  = 2'd1;
  localparam logic [1:0] REG_COMMAND = 2'd2;
  localparam logic [1:0] REG_HOLD    = 2'd3;

  localparam logic [1:0] CMD_ENABLE  = 2'b01;
  localparam logic [1:0] CMD_DISABLE = 2'b10;
  localparam logic [3:0] MISC_RST_MR = 4'h1;
  localparam logic [3:0] MISC_RST_RX = 4'h2;

  logic       rx_en_q, rx_en_d;
  logic       tx_en_q, tx_en_d;
  logic       mode_ptr_q, mode_ptr_d;
  logic [7:0] mode_q [2];
  logic       mode_we;
  logic       hit;
  logic [1:0] reg_idx;
  logic       rx_nz;
  ucrf_fifo_ctl_t ctl;
  ucrf_out_t      res;

  assign hit     = (item_i.address[3:2] == (port_sel_i ? BANK_B : BANK_A));
  assign reg_idx = item_i.address[1:0];
  assign rx_nz   = (fifo_sts_i.count != '0);

  always_comb begin
    rx_en_d    = rx_en_q;
    tx_en_d    = tx_en_q;
    mode_ptr_d = mode_ptr_q;
    mode_we    = 1'b0;
    ctl        = '0;
    ctl.wdata  = item_i.data;
    res        = '0;

    unique case (item_i.operation)
      OP_READ: begin
        if (hit) begin
          unique case (reg_idx)
            REG_MODE: begin
              res.read_data = mode_q[mode_ptr_q];
              mode_ptr_d    = 1'b1;
            end
            REG_STATUS: begin
              res.read_data = {4'b0000, tx_en_q, tx_en_q,
                               (fifo_sts_i.count > CNT_TWO), rx_nz};
            end
            REG_HOLD: begin
              if (rx_nz) begin
                res.read_data = fifo_sts_i.head_data;
                ctl.pop       = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      OP_WRITE: begin
        if (hit) begin
          unique case (reg_idx)
            REG_MODE: begin
              mode_we    = 1'b1;
              mode_ptr_d = 1'b1;
            end
            REG_COMMAND: begin
              if (item_i.data[1:0] == CMD_ENABLE)  rx_en_d = 1'b1;
              if (item_i.data[1:0] == CMD_DISABLE) rx_en_d = 1'b0;
              if (item_i.data[3:2] == CMD_ENABLE)  tx_en_d = 1'b1;
              if (item_i.data[3:2] == CMD_DISABLE) tx_en_d = 1'b0;
              if (item_i.data[7:4] == MISC_RST_MR) begin
                mode_ptr_d = 1'b0;
              end else if (item_i.data[7:4] == MISC_RST_RX) begin
                rx_en_d   = 1'b0;
                ctl.clear = 1'b1;
              end
            end
            REG_HOLD: begin
              if (tx_en_q) begin
                res.tx_valid = 1'b1;
                res.tx_data  = item_i.data;
              end
            end
            // Clock select: baud generation lives outside, nothing to hold
            default: ;
          endcase
        end
      end
      OP_RX: begin
        // Drop the byte when the receiver is off or the FIFO is full
        if (rx_en_q && (fifo_sts_i.count < CNT_MAX)) begin
          ctl.push = 1'b1;
        end
      end
      default: ;
    endcase

    res.irq_tx_ready = tx_en_d;
    if (ctl.clear) begin
      res.irq_rx_ready = 1'b0;
    end else if (ctl.push) begin
      res.irq_rx_ready = 1'b1;
    end else if (ctl.pop) begin
      res.irq_rx_ready = (fifo_sts_i.count != CNT_ONE);
    end else begin
      res.irq_rx_ready = rx_nz;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_en_q    <= 1'b0;
      tx_en_q    <= 1'b0;
      mode_ptr_q <= 1'b0;
      mode_q[0]  <= '0;
      mode_q[1]  <= '0;
    end else if (fire_i) begin
      rx_en_q    <= rx_en_d;
      tx_en_q    <= tx_en_d;
      mode_ptr_q <= mode_ptr_d;
      if (mode_we) begin
        mode_q[mode_ptr_q] <= item_i.data;
      end
    end
  end

  assign fifo_ctl_o.push  = fire_i & ctl.push;
  assign fifo_ctl_o.pop   = fire_i & ctl.pop;
  assign fifo_ctl_o.clear = fire_i & ctl.clear;
  assign fifo_ctl_o.wdata = ctl.wdata;
  assign result_o         = res;

endmodule
